@@ hdl/drs_pkg.sv @@
// drs_pkg: constants and types shared by the double radix sorter modules
// no dependencies

package drs_pkg;

    localparam int MAX_ITEMS     = 64;
    localparam int RADIX_BUCKETS = 256;
    localparam int DATA_W        = 64;
    localparam int ADDR_W        = $clog2(MAX_ITEMS);
    localparam int CNT_W         = $clog2(MAX_ITEMS + 1);
    localparam int DIGIT_W       = 8;
    localparam int PASS_W        = 4;
    localparam int NUM_PASSES    = 9;

    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    // bucket table commands
    typedef struct packed {
        logic   wr;
        digit_t waddr;
        cnt_t   wdata;
        digit_t raddr;
    } bkt_cmd_t;

    function automatic digit_t digit_of(input data_t v, input logic [PASS_W-1:0] pass);
        logic [2:0] k;
        begin
            k = (pass >= PASS_W'(8)) ? 3'd7 : pass[2:0];
            digit_of = v[k*8 +: 8];
        end
    endfunction

endpackage

@@ hdl/drs_data_ram.sv @@
// drs_data_ram: element buffer, one write port and one registered read port
// depends on drs_pkg

module drs_data_ram (
    input  logic          clk,
    input  logic          we,
    input  drs_pkg::addr_t waddr,
    input  drs_pkg::data_t wdata,
    input  drs_pkg::addr_t raddr,
    output drs_pkg::data_t rdata
);
    import drs_pkg::*;

    data_t mem [MAX_ITEMS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/drs_bucket_ram.sv @@
// drs_bucket_ram: bucket count and position table, 256 entries
// depends on drs_pkg

module drs_bucket_ram (
    input  logic              clk,
    input  drs_pkg::bkt_cmd_t cmd,
    output drs_pkg::cnt_t     rdata
);
    import drs_pkg::*;

    cnt_t mem [RADIX_BUCKETS];

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
        rdata <= mem[cmd.raddr];
    end

endmodule

@@ hdl/double_radix_sorter.sv @@
// double_radix_sorter: top level, load / sort / emit sequencer
// depends on drs_pkg, drs_data_ram, drs_bucket_ram
//
// Loads up to 64 double bit patterns, one per start transaction, a new one
// every cycle while busy is low. The transaction with is_last set raises busy;
// the block then runs nine counting passes (eight byte passes by raw pattern,
// then a top byte pass that puts negatives first in reverse) over two 64-entry
// buffers and a 256-entry bucket table, and emits the n sorted items on
// consecutive cycles with strobe high. Each pass runs a clear, a count, a prefix
// and a scatter phase over the bucket table, which has one write port and one
// registered read port.
// Results cannot be stalled: the receiver must take one per strobe.

module double_radix_sorter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  drs_pkg::data_t value_bits,
    input  logic           is_last,
    output logic           strobe,
    output drs_pkg::data_t sorted_bits,
    output logic           last_out,
    output logic           overflowed
);
    import drs_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_CLEAR, S_COUNT, S_PREFIX, S_SCAT_RD, S_SCAT_WR, S_EMIT
    } state_t;

    state_t            state_reg;
    logic [PASS_W-1:0] pass_reg;
    cnt_t              n_reg;
    logic              drop_reg;
    logic [8:0]        idx_reg;       // bucket/item sweep index
    logic              rd_v_reg;      // read issued last cycle
    logic              rd_v2_reg;
    digit_t            d_pipe_reg;
    cnt_t              acc_reg;
    data_t             val_reg;
    logic              src_a_reg;     // pass reads from buffer a
    logic              scat_step_reg; // scatter read step: 0 issue address, 1 capture data
    cnt_t              emit_reg;

    // memories
    logic   a_we, b_we;
    addr_t  a_waddr, b_waddr, a_raddr, b_raddr;
    data_t  a_wdata, b_wdata, a_rdata, b_rdata;
    bkt_cmd_t bcmd;
    cnt_t   b_rd;
    data_t  src_rdata;

    drs_data_ram u_buf_a (.clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
                          .raddr(a_raddr), .rdata(a_rdata));
    drs_data_ram u_buf_b (.clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
                          .raddr(b_raddr), .rdata(b_rdata));
    drs_bucket_ram u_bkt (.clk, .cmd(bcmd), .rdata(b_rd));

    assign src_rdata = src_a_reg ? a_rdata : b_rdata;
    assign busy = (state_reg != S_LOAD);

    logic   sign_pass;
    digit_t cur_d;
    logic   neg;
    logic   accept;
    cnt_t   pos_new;

    assign sign_pass = (pass_reg == PASS_W'(NUM_PASSES - 1));
    assign cur_d     = digit_of(src_rdata, pass_reg);
    // element being written back is negative: sign pass and top bit of its digit, held from the read step
    assign neg       = sign_pass && d_pipe_reg[7];
    assign accept    = start && !busy;
    assign pos_new   = neg ? b_rd - 1'b1 : b_rd;

    // prefix order: normal 0..255; sign pass 255..128 then 0..127
    digit_t pfx_d;
    assign pfx_d = (sign_pass) ? ((idx_reg < 9'd128) ? digit_t'(8'd255 - idx_reg[7:0])
                                                    : digit_t'(idx_reg[7:0] - 8'd128))
                               : idx_reg[7:0];
    digit_t pfx_d_reg;

    always_comb
    begin
        a_we = 1'b0; b_we = 1'b0;
        a_waddr = '0; b_waddr = '0;
        a_wdata = value_bits; b_wdata = value_bits;
        a_raddr = idx_reg[ADDR_W-1:0];
        b_raddr = state_reg == S_EMIT ? emit_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
        bcmd = '{wr: 1'b0, waddr: '0, wdata: '0, raddr: '0};
        unique case (state_reg)
            S_LOAD:
            begin
                a_we    = accept && (n_reg != cnt_t'(MAX_ITEMS));
                a_waddr = n_reg[ADDR_W-1:0];
            end
            S_CLEAR:
            begin
                bcmd.wr    = 1'b1;
                bcmd.waddr = idx_reg[7:0];
            end
            S_COUNT:
            begin
                // read bucket of item, then write +1 in the next cycle
                bcmd.raddr = cur_d;
                if (rd_v2_reg)
                begin
                    bcmd.wr    = 1'b1;
                    bcmd.waddr = d_pipe_reg;
                    bcmd.wdata = b_rd + 1'b1;
                end
            end
            S_PREFIX:
            begin
                bcmd.raddr = pfx_d;
                if (rd_v_reg)
                begin
                    bcmd.wr    = 1'b1;
                    bcmd.waddr = pfx_d_reg;
                    bcmd.wdata = (sign_pass && pfx_d_reg[7]) ? acc_reg + b_rd : acc_reg;
                end
            end
            S_SCAT_RD:
            begin
                bcmd.raddr = cur_d;
            end
            S_SCAT_WR:
            begin
                bcmd.wr    = 1'b1;
                bcmd.waddr = d_pipe_reg;
                bcmd.wdata = neg ? pos_new : b_rd + 1'b1;
                if (src_a_reg)
                begin
                    b_we = 1'b1; b_waddr = pos_new[ADDR_W-1:0]; b_wdata = val_reg;
                end
                else
                begin
                    a_we = 1'b1; a_waddr = pos_new[ADDR_W-1:0]; a_wdata = val_reg;
                end
            end
            S_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            pass_reg      <= '0;
            n_reg         <= '0;
            drop_reg      <= 1'b0;
            idx_reg       <= '0;
            rd_v_reg      <= 1'b0;
            rd_v2_reg     <= 1'b0;
            d_pipe_reg    <= '0;
            pfx_d_reg     <= '0;
            acc_reg       <= '0;
            val_reg       <= '0;
            src_a_reg     <= 1'b1;
            scat_step_reg <= 1'b0;
            emit_reg      <= '0;
            strobe        <= 1'b0;
            sorted_bits   <= '0;
            last_out      <= 1'b0;
            overflowed    <= 1'b0;
        end
        else
        begin
            strobe <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (n_reg != cnt_t'(MAX_ITEMS))
                            n_reg <= n_reg + 1'b1;
                        else
                            drop_reg <= 1'b1;
                        if (is_last)
                        begin
                            state_reg <= S_CLEAR;
                            pass_reg  <= '0;
                            src_a_reg <= 1'b1;
                            idx_reg   <= '0;
                        end
                    end
                end
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == 9'd255)
                    begin
                        // prime the first element read
                        idx_reg   <= '0;
                        rd_v_reg  <= 1'b0;
                        rd_v2_reg <= 1'b0;
                        state_reg <= S_COUNT;
                    end
                end
                S_COUNT:
                begin
                    // stage 1: element read (idx); stage 2: bucket read; stage 3: write
                    // back-to-back hazard avoided by reading the next element only after
                    // the previous element's bucket write
                    if (!rd_v_reg && !rd_v2_reg)
                    begin
                        if (idx_reg[CNT_W-1:0] == n_reg)
                        begin
                            idx_reg   <= '0;
                            acc_reg   <= '0;
                            rd_v_reg  <= 1'b0;
                            state_reg <= S_PREFIX;
                        end
                        else
                        begin
                            rd_v_reg <= 1'b1;
                            idx_reg  <= idx_reg + 1'b1;
                        end
                    end
                    else if (rd_v_reg)
                    begin
                        rd_v_reg   <= 1'b0;
                        rd_v2_reg  <= 1'b1;
                        d_pipe_reg <= cur_d;
                    end
                    else
                    begin
                        rd_v2_reg <= 1'b0;
                    end
                end
                S_PREFIX:
                begin
                    rd_v_reg  <= (idx_reg < 9'd256);
                    pfx_d_reg <= pfx_d;
                    if (idx_reg < 9'd256)
                        idx_reg <= idx_reg + 1'b1;
                    if (rd_v_reg)
                        acc_reg <= acc_reg + b_rd;
                    if (rd_v_reg && idx_reg == 9'd256)
                    begin
                        idx_reg   <= '0;
                        rd_v_reg  <= 1'b0;
                        state_reg <= S_SCAT_RD;
                        scat_step_reg <= 1'b0;
                    end
                end
                S_SCAT_RD:
                begin
                    // element address idx issued in step 0; data present in step 1
                    if (!scat_step_reg)
                    begin
                        if (idx_reg[CNT_W-1:0] == n_reg)
                        begin
                            idx_reg   <= '0;
                            src_a_reg <= !src_a_reg;
                            if (sign_pass)
                            begin
                                emit_reg  <= '0;
                                rd_v_reg  <= 1'b0;
                                state_reg <= S_EMIT;
                            end
                            else
                            begin
                                pass_reg  <= pass_reg + 1'b1;
                                state_reg <= S_CLEAR;
                            end
                        end
                        else
                            scat_step_reg <= 1'b1;
                    end
                    else
                    begin
                        scat_step_reg <= 1'b0;
                        d_pipe_reg    <= cur_d;
                        val_reg       <= src_rdata;
                        idx_reg       <= idx_reg + 1'b1;
                        state_reg     <= S_SCAT_WR;
                    end
                end
                S_SCAT_WR:
                begin
                    state_reg <= S_SCAT_RD;
                end
                S_EMIT:
                begin
                    // buffer b holds the result; its read port is registered
                    rd_v_reg <= (emit_reg != n_reg);
                    if (emit_reg != n_reg)
                        emit_reg <= emit_reg + 1'b1;
                    if (rd_v_reg)
                    begin
                        strobe      <= 1'b1;
                        sorted_bits <= b_rdata;
                        last_out    <= (emit_reg == n_reg);
                        overflowed  <= drop_reg;
                    end
                    if (rd_v_reg && emit_reg == n_reg)
                    begin
                        rd_v_reg  <= 1'b0;
                        n_reg     <= '0;
                        drop_reg  <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

endmodule
